/* rtl/weh_pkg.sv */
// Shared types, constants and register map of the weighted energy histogram.
package weh_pkg;
  localparam int NumBlocks = 5;
  localparam int MaxBins = 128;
  localparam int Comps = 4;
  localparam int BlkW = 3;
  localparam int BinW = 7;
  localparam int AddrW = 10;
  localparam int MemDepth = NumBlocks * MaxBins;
  localparam int MemAw = $clog2(MemDepth);

  localparam logic [2:0] RegSampleEvery = 3'd0;
  localparam logic [2:0] RegRangeLow = 3'd1;
  localparam logic [2:0] RegBinScale = 3'd2;
  localparam logic [2:0] RegNumBins = 3'd3;

  localparam logic CmdAdd = 1'b0;
  localparam logic CmdRead = 1'b1;

  // Lane result: bin found for one component.
  typedef struct packed {
    logic       hit;
    logic [BinW-1:0] bin;
  } lane_res_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {33'd0, b};
    return s[64] ? '1 : s[63:0];
  endfunction
endpackage

/* rtl/weh_mod.sv */
// Serial remainder unit: one quotient bit per cycle, reports divisibility.
module weh_mod (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic done,
  output logic zero_rem
);
  import weh_pkg::*;
  logic [31:0] rem, quo, dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dsr};

  // Shift and subtract, one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= (divisor == 32'd0) ? 32'd1 : divisor;
        cnt  <= 6'd32;
      end else if (busy) begin
        if (!trial[32]) rem <= trial[31:0];
        else rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign zero_rem = (rem == 32'd0);
endmodule

/* rtl/weh_lane.sv */
// One binning lane: offset, scale and range check of an energy component.
module weh_lane (
  input  logic clk,
  input  logic [47:0] energy,
  input  logic [47:0] range_low,
  input  logic [31:0] bin_scale,
  input  logic [7:0]  nb,
  output weh_pkg::lane_res_t res
);
  import weh_pkg::*;
  logic [48:0] diff, mag;
  logic        neg, neg_q;
  logic [16:0] hi_q;
  logic [31:0] lo_q, s_q;
  logic [48:0] p_hi, p_lo;
  logic [63:0] lo_prod;
  logic [48:0] hi_prod;
  logic [49:0] q;
  logic [7:0]  nb_q;

  assign diff = {energy[47], energy} - {range_low[47], range_low};
  assign neg  = diff[48];
  assign mag  = neg ? (49'd0 - diff) : diff;

  // Stage 1: register magnitude split
  always_ff @(posedge clk) begin
    neg_q <= neg;
    hi_q  <= mag[48:32];
    lo_q  <= mag[31:0];
    s_q   <= bin_scale;
    nb_q  <= nb;
  end

  assign lo_prod = {32'd0, lo_q} * {32'd0, s_q};
  assign hi_prod = {32'd0, hi_q} * {17'd0, s_q};

  // Stage 2: register the two partial products
  always_ff @(posedge clk) begin
    p_lo <= {17'd0, lo_prod[63:32]};
    p_hi <= hi_prod;
  end

  assign q = {1'b0, p_hi} + {1'b0, p_lo};

  // Range check; a negative offset only survives when it truncates to zero
  always_comb begin
    res.bin = q[BinW-1:0];
    if (neg_q && q != 50'd0) res.hit = 1'b0;
    else res.hit = (q < {42'd0, nb_q});
  end
endmodule

/* rtl/weighted_energy_histogram.sv */
// Top level: weighted energy histogram with four binning lanes and shared bin store.
// A sample transaction passes through the serial divisibility test of the cycle number
// (32 shift-subtract steps and the done flag), two lane stages, a bin store read, a read
// wait, a write and the output stage. The next transaction is taken once the sequencer
// is back in idle. A read command passes through the bin store read, the read wait and
// the output stage. Reset starts a clearing pass over all 640 addresses of the bin
// store; no item is taken during it. One item is processed at a time. A finished result
// waits in the output register while the next transaction is taken and processed; that
// one holds in the output stage until the waiting result is taken.
module weighted_energy_histogram (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // tdata: command[0], block_index[3:1], cycle_number[35:4], total_energy[83:36],
  // vdw_energy[131:84], coulomb_energy[179:132], polarization_energy[227:180],
  // weight[259:228], read_bin[266:260], zero pad to 272
  input  logic [271:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata: was_sampled[0], total_sum[64:1], vdw_sum[128:65], coulomb_sum[192:129],
  // polarization_sum[256:193], block_count[320:257], zero pad to 328
  output logic [327:0] m_tdata,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  import weh_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_LANE1, S_LANE2, S_RD, S_RDWAIT, S_WR, S_OUT
  } state_t;

  state_t state;
  logic [31:0] sample_every, bin_scale;
  logic [47:0] range_low;
  logic [7:0]  num_bins;
  logic        cmd;
  logic [BlkW-1:0] blk;
  logic [31:0] wgt;
  logic [47:0] en [Comps];
  logic [BinW-1:0] rbin;
  logic [MemAw-1:0] clr_addr;
  logic [63:0] mem [Comps][MemDepth];
  logic [63:0] rd_q [Comps];
  logic [63:0] blk_cnt [NumBlocks];
  lane_res_t   lres [Comps];
  lane_res_t   lres_q [Comps];
  logic        mod_start, mod_done, mod_zero;
  logic [7:0]  nb;
  logic        blk_ok;
  logic [63:0] out_sum [Comps];
  logic [63:0] out_cnt;
  logic        out_smp;
  logic        wr_cfg;

  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite;
  assign nb = (num_bins > 8'(MaxBins)) ? 8'(MaxBins) : num_bins;
  assign blk_ok = (blk < BlkW'(NumBlocks));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_every <= 32'd1;
      range_low    <= '0;
      bin_scale    <= 32'd65536;
      num_bins     <= 8'd128;
    end else if (wr_cfg) begin
      case (paddr[4:3])
        RegSampleEvery[1:0]: sample_every <= pwdata[31:0];
        RegRangeLow[1:0]:    range_low    <= pwdata[47:0];
        RegBinScale[1:0]:    bin_scale    <= pwdata[31:0];
        RegNumBins[1:0]:     num_bins     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      RegSampleEvery[1:0]: prdata = {32'd0, sample_every};
      RegRangeLow[1:0]:    prdata = {{16{range_low[47]}}, range_low};
      RegBinScale[1:0]:    prdata = {32'd0, bin_scale};
      RegNumBins[1:0]:     prdata = {56'd0, num_bins};
      default:             prdata = '0;
    endcase
  end

  weh_mod u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(s_tdata[35:4]),
    .divisor(sample_every), .done(mod_done), .zero_rem(mod_zero)
  );

  for (genvar g = 0; g < Comps; g++) begin : g_lane
    weh_lane u_lane (
      .clk(clk), .energy(en[g]), .range_low(range_low), .bin_scale(bin_scale),
      .nb(nb), .res(lres[g])
    );
  end

  assign s_tready = (state == S_IDLE);
  assign mod_start = s_tvalid && s_tready && (s_tdata[0] == CmdAdd);

  // Bin store: one read and one write port per lane
  always_ff @(posedge clk) begin
    for (int k = 0; k < Comps; k++) begin
      if (state == S_CLEAR) mem[k][clr_addr] <= '0;
      else if (state == S_WR && lres_q[k].hit && blk_ok && mod_zero)
        mem[k][MemAw'(blk) * MemAw'(MaxBins) + MemAw'(lres_q[k].bin)] <=
          sat_add(rd_q[k], wgt);
      rd_q[k] <= mem[k][MemAw'(blk) * MemAw'(MaxBins) +
                 MemAw'(cmd == CmdRead ? rbin : lres_q[k].bin)];
    end
  end

  // Sequencer and merge
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      for (int b = 0; b < NumBlocks; b++) blk_cnt[b] <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == MemAw'(MemDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_tvalid && s_tready) begin
          cmd  <= s_tdata[0];
          blk  <= s_tdata[3:1];
          en[0] <= s_tdata[83:36];
          en[1] <= s_tdata[131:84];
          en[2] <= s_tdata[179:132];
          en[3] <= s_tdata[227:180];
          wgt  <= s_tdata[259:228];
          rbin <= s_tdata[266:260];
          state <= (s_tdata[0] == CmdRead) ? S_RD : S_MOD;
        end
        S_MOD: if (mod_done) state <= S_LANE1;
        S_LANE1: state <= S_LANE2;
        S_LANE2: begin
          lres_q <= lres;
          state  <= S_RD;
        end
        S_RD: state <= S_RDWAIT;
        S_RDWAIT: state <= (cmd == CmdRead) ? S_OUT : S_WR;
        S_WR: begin
          if (blk_ok && mod_zero) blk_cnt[blk] <= sat_add(blk_cnt[blk], wgt);
          state <= S_OUT;
        end
        // Hold until the output register is free or being emptied
        S_OUT: if (!m_tvalid || m_tready) begin
          out_smp <= (cmd == CmdAdd) && blk_ok && mod_zero;
          for (int k = 0; k < Comps; k++)
            out_sum[k] <= (cmd == CmdRead && blk_ok) ? rd_q[k] : '0;
          out_cnt <= (cmd == CmdRead && blk_ok) ? blk_cnt[blk] : '0;
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, out_cnt, out_sum[3], out_sum[2], out_sum[1], out_sum[0], out_smp};

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("input taken while busy");
  a_out_after_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> m_tvalid) else $error("result not presented");
  a_read_no_sample: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_smp) |-> (out_cnt == 64'd0)) else $error("sample result carries count");
`endif
endmodule

/* dv/tb_weighted_energy_histogram.sv */
// Self-checking testbench for the weighted energy histogram: directed table, then random phases.
module tb_weighted_energy_histogram;
  import weh_pkg::*;

  typedef struct packed {
    bit              cmd;
    bit [2:0]        blk;
    bit [31:0]       cyc;
    bit [3:0][47:0]  en;
    bit [31:0]       wgt;
    bit [6:0]        rbin;
  } sample_t;

  typedef struct packed {
    bit             smp;
    bit [3:0][63:0] sums;
    bit [63:0]      cnt;
  } bin_read_t;

  typedef struct packed {
    sample_t   item;
    bit        typed;
    bin_read_t want;
  } stim_row_t;

  localparam bit [31:0] One = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [271:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [327:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  // Shadow copy of the histogram store and its settings
  bit [63:0] hist_q [NumBlocks][Comps][MaxBins];
  bit [63:0] blk_cnt_q [NumBlocks];
  bit [31:0] sample_every_q = 32'd1;
  bit [47:0] range_low_q = '0;
  bit [31:0] bin_scale_q = One;
  bit [7:0]  num_bins_q = 8'd128;

  bin_read_t bin_reads_due [$];
  int errors = 0;
  int sent = 0;
  int reads_sent = 0;
  int samples_taken = 0;
  int results_seen = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_cnt = 0;
  int ready_phase = 0;
  int burst_left = 0;

  weighted_energy_histogram u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Work out which bin an energy falls in; 0 when dropped
  function automatic bit bin_lookup(input bit [47:0] energy, input bit [63:0] nb,
                                    output bit [63:0] bin);
    longint diff;
    bit [63:0] mag, q;
    diff = longint'($signed(energy)) - longint'($signed(range_low_q));
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    q = (mag >> 32) * 64'(bin_scale_q) + (((mag & 64'hFFFF_FFFF) * 64'(bin_scale_q)) >> 32);
    bin = q;
    if (diff < 0 && q != 0) return 1'b0;
    bin = (diff < 0) ? 64'd0 : q;
    return bin < nb;
  endfunction

  function automatic bit [63:0] sat_sum(input bit [63:0] a, input bit [31:0] b);
    bit [64:0] s;
    s = {1'b0, a} + 65'(b);
    return s[64] ? '1 : s[63:0];
  endfunction

  // Apply one item to the shadow store and return its result
  function automatic bin_read_t predict_histogram(input sample_t it);
    bin_read_t r;
    bit [63:0] div, nb, bin;
    r = '0;
    if (it.cmd == CmdRead) begin
      if (it.blk < NumBlocks) begin
        for (int k = 0; k < Comps; k++) r.sums[k] = hist_q[it.blk][k][it.rbin];
        r.cnt = blk_cnt_q[it.blk];
      end
      return r;
    end
    div = (sample_every_q == 0) ? 64'd1 : 64'(sample_every_q);
    nb = (num_bins_q < MaxBins) ? 64'(num_bins_q) : 64'(MaxBins);
    if (64'(it.cyc) % div != 0 || it.blk >= NumBlocks) return r;
    for (int k = 0; k < Comps; k++)
      if (bin_lookup(it.en[k], nb, bin))
        hist_q[it.blk][k][bin] = sat_sum(hist_q[it.blk][k][bin], it.wgt);
    blk_cnt_q[it.blk] = sat_sum(blk_cnt_q[it.blk], it.wgt);
    r.smp = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input bit [63:0] got, input bit [63:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h", results_seen, what, got, want);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic reg_write(input logic [2:0] idx, input bit [63:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx[1:0], 3'b000}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegSampleEvery: sample_every_q = val[31:0];
      RegRangeLow:    range_low_q = val[47:0];
      RegBinScale:    bin_scale_q = val[31:0];
      RegNumBins:     num_bins_q = val[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (bin_reads_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_config(input bit [31:0] se, input bit [47:0] rl, input bit [31:0] sc,
                            input bit [7:0] nb);
    s_tvalid <= 1'b0;
    wait_idle();
    reg_write(RegSampleEvery, 64'(se));
    reg_write(RegRangeLow, 64'(rl));
    reg_write(RegBinScale, 64'(sc));
    reg_write(RegNumBins, 64'(nb));
  endtask

  // Offer one transaction; hold it until taken, then predict its result
  task automatic send_item(input sample_t it, input bit typed, input bin_read_t want);
    bin_read_t got;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, it.rbin, it.wgt, it.en[3], it.en[2], it.en[1], it.en[0],
                it.cyc, it.blk, it.cmd};
    do @(posedge clk); while (!s_tready);
    got = predict_histogram(it);
    bin_reads_due.push_back(typed ? want : got);
    sent++;
    if (it.cmd == CmdRead) reads_sent++;
    if (got.smp) samples_taken++;
    burst_left--;
    @(negedge clk);
  endtask

  // Random item: mostly energies near the binned range, cycles on the sampling grid
  function automatic sample_t random_item();
    sample_t it;
    bit [63:0] unit, nb, span;
    it.cmd = ($urandom_range(0, 9) < 3) ? CmdRead : CmdAdd;
    it.blk = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    it.cyc = $urandom;
    if ($urandom_range(0, 9) < 7)
      it.cyc = (sample_every_q > 32'h0010_0000) ? ($urandom_range(0, 1) ? sample_every_q : 0)
                                                : sample_every_q * $urandom_range(0, 4000);
    unit = (bin_scale_q == 0) ? 64'h1_0000 : (64'h1_0000_0000 / 64'(bin_scale_q)) + 1;
    if (unit > 64'h1_0000_0000) unit = 64'h1_0000_0000;
    nb = (num_bins_q == 0) ? 64'd1 : 64'(num_bins_q);
    span = (nb + 4) * unit;
    for (int k = 0; k < Comps; k++) begin
      if ($urandom_range(0, 9) < 7)
        it.en[k] = range_low_q + 48'({$urandom, $urandom} % span) - 48'(2 * unit);
      else
        it.en[k] = {16'($urandom), $urandom};
    end
    case ($urandom_range(0, 5))
      0: it.wgt = '1;
      1: it.wgt = 32'($urandom_range(0, 3)) << 16;
      default: it.wgt = $urandom;
    endcase
    it.rbin = ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                          : 7'($urandom_range(0, 32'(nb - 1)));
    return it;
  endfunction

  // Result checker
  always @(posedge clk) begin
    bin_read_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.smp = m_tdata[0];
      for (int k = 0; k < Comps; k++) got.sums[k] = m_tdata[64*k+1 +: 64];
      got.cnt = m_tdata[320:257];
      results_seen++;
      if (bin_reads_due.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'd0);
      end else begin
        want = bin_reads_due.pop_front();
        if (got.smp != want.smp) report_mismatch("was_sampled", 64'(got.smp), 64'(want.smp));
        for (int k = 0; k < Comps; k++)
          if (got.sums[k] != want.sums[k])
            report_mismatch($sformatf("sum of component %0d", k), got.sums[k], want.sums[k]);
        if (got.cnt != want.cnt) report_mismatch("block_count", got.cnt, want.cnt);
      end
    end
  end

  // Receiver: stall pattern with quiet stretches, plus requested long hold-offs
  always @(negedge clk) begin
    if (hold_reqs != holds_done) begin
      holds_done <= hold_reqs;
      hold_cnt <= 400;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      ready_phase <= (ready_phase + 1) % 96;
      m_tready <= (ready_phase < 30) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", bin_reads_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    sample_t it;
    bin_read_t none;
    none = '0;
    foreach (hist_q[b, c, n]) hist_q[b][c][n] = '0;
    foreach (blk_cnt_q[b]) blk_cnt_q[b] = '0;

    // Directed table: typed results where obvious, else predicted
    row = '0; row.item.cmd = CmdRead; row.typed = 1'b1; rows.push_back(row);
    row.item.blk = 3'd7; row.item.rbin = 7'd127; rows.push_back(row);
    row = '0; row.item.cmd = CmdAdd; row.item.wgt = One; row.typed = 1'b1; row.want.smp = 1'b1;
    row.item.en[1] = 48'h1_8000; row.item.en[2] = 48'h7F_FFFF; row.item.en[3] = 48'h80_0000;
    rows.push_back(row);
    row.item.blk = 3'd5; row.want.smp = 1'b0; rows.push_back(row);
    row.item.blk = 3'd7; row.item.cyc = '1; row.item.wgt = '1; rows.push_back(row);
    row = '0; row.item.blk = 3'd4; row.item.wgt = '1; row.typed = 1'b1; row.want.smp = 1'b1;
    row.item.en[0] = -48'sh8000; row.item.en[1] = -48'sh1_0000;
    row.item.en[2] = 48'h7FFF_FFFF_FFFF; row.item.en[3] = 48'h8000_0000_0000;
    row.item.cyc = '1; rows.push_back(row);
    row.item.en[0] = 48'h2_0000; row.item.blk = 3'd0; row.item.cyc = 32'h5555_AAAA;
    rows.push_back(row);
    row = '0; row.item.cmd = CmdRead; rows.push_back(row);
    row.item.rbin = 7'd1; rows.push_back(row);
    row.item.rbin = 7'd2; rows.push_back(row);
    row.item.rbin = 7'd127; rows.push_back(row);
    row.item.blk = 3'd4; row.item.rbin = 7'd0; rows.push_back(row);
    row.item.rbin = 7'd127; rows.push_back(row);
    row.item.blk = 3'd5; row.typed = 1'b1; rows.push_back(row);
    row.item.blk = 3'd6; row.item.rbin = 7'd0; rows.push_back(row);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    // Random phases, each under its own settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_config(32'd3, -48'sh5_0000, 32'h2_0000, 8'd10);
        2: set_config(32'd0, 48'h7FFF_FFFF_FFFF, 32'd0, 8'd0);
        3: set_config(32'hFFFF_FFFF, 48'h8000_0000_0000, 32'hFFFF_FFFF, 8'd255);
        4: set_config(32'd1, 48'h7_0000, 32'h8000, 8'd1);
        5: set_config(32'd2, 48'd0, One, 8'd128);
        default: ;
      endcase
      for (int n = 0; n < 205; n++) begin
        if (ph == 0 && n == 40) hold_reqs++;
        it = random_item();
        send_item(it, 1'b0, none);
      end
    end
    s_tvalid <= 1'b0;

    wait_idle();
    $display("Sent %0d items (%0d reads, %0d samples binned); %0d results checked",
             sent, reads_sent, samples_taken, results_seen);
    $display("Covered six register settings including zero and full-scale extremes");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/weh_pkg.sv
rtl/weh_mod.sv
rtl/weh_lane.sv
rtl/weighted_energy_histogram.sv
dv/tb_weighted_energy_histogram.sv
